// ===== design/gfd_pkg.sv =====
package gfd_pkg;

    localparam logic [7:0] START_BYTE = 8'h3E;

    localparam logic [2:0] ST_DROP = 3'd0;
    localparam logic [2:0] ST_HDR  = 3'd1;
    localparam logic [2:0] ST_DATA = 3'd2;
    localparam logic [2:0] ST_OK   = 3'd3;
    localparam logic [2:0] ST_HERR = 3'd4;
    localparam logic [2:0] ST_BERR = 3'd5;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_CMD  = 3'd1,
        PH_LEN  = 3'd2,
        PH_HCHK = 3'd3,
        PH_BODY = 3'd4,
        PH_BCHK = 3'd5
    } t_phase;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] command_id;
        logic [7:0] payload_length;
    } t_result;

endpackage

// ===== design/gfd_if.sv =====
interface gfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface gfd_out_if;
    import gfd_pkg::*;

    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/gfd_parser.sv =====
module gfd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    output gfd_pkg::t_result o_res
);
    import gfd_pkg::*;

    t_phase     r_phase;
    t_phase     n_phase;
    logic [7:0] r_cmd;
    logic [7:0] n_cmd;
    logic [7:0] r_len;
    logic [7:0] n_len;
    logic [7:0] r_seen;
    logic [7:0] n_seen;
    logic [7:0] r_sum;
    logic [7:0] n_sum;
    logic [7:0] w_seen_inc;
    logic       w_hdr_ok;

    assign w_seen_inc = r_seen + 8'd1;
    assign w_hdr_ok   = (i_byte == (r_cmd + r_len));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_cmd   <= '0;
            r_len   <= '0;
            r_seen  <= '0;
            r_sum   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_seen  <= n_seen;
            r_sum   <= n_sum;
        end
    end

    always_comb begin
        unique case (r_phase)
            PH_CMD:  n_phase = PH_LEN;
            PH_LEN:  n_phase = PH_HCHK;
            PH_HCHK: begin
                if (!w_hdr_ok) begin
                    n_phase = PH_HUNT;
                end else if (r_len == 8'd0) begin
                    n_phase = PH_BCHK;
                end else begin
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: n_phase = (w_seen_inc == r_len) ? PH_BCHK : PH_BODY;
            PH_BCHK: n_phase = PH_HUNT;
            default: n_phase = (i_byte == START_BYTE) ? PH_CMD : PH_HUNT;
        endcase
    end

    always_comb begin
        n_cmd  = r_cmd;
        n_len  = r_len;
        n_seen = r_seen;
        n_sum  = r_sum;
        o_res.status        = ST_DROP;
        o_res.payload_byte  = '0;
        o_res.payload_index = '0;
        unique case (r_phase)
            PH_CMD: begin
                n_cmd        = i_byte;
                o_res.status = ST_HDR;
            end
            PH_LEN: begin
                n_len        = i_byte;
                o_res.status = ST_HDR;
            end
            PH_HCHK: begin
                if (w_hdr_ok) begin
                    o_res.status = ST_HDR;
                    n_seen       = '0;
                    n_sum        = '0;
                end else begin
                    o_res.status = ST_HERR;
                end
            end
            PH_BODY: begin
                o_res.status        = ST_DATA;
                o_res.payload_byte  = i_byte;
                o_res.payload_index = r_seen;
                n_sum               = r_sum + i_byte;
                n_seen              = w_seen_inc;
            end
            PH_BCHK: begin
                o_res.status = (i_byte == r_sum) ? ST_OK : ST_BERR;
            end
            default: begin
                if (i_byte == START_BYTE) begin
                    n_cmd        = '0;
                    n_len        = '0;
                    n_seen       = '0;
                    n_sum        = '0;
                    o_res.status = ST_HDR;
                end
            end
        endcase
        o_res.command_id     = (o_res.status == ST_DROP) ? 8'd0 : n_cmd;
        o_res.payload_length = (o_res.status == ST_DROP) ? 8'd0 : n_len;
    end

    a_body_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BODY |-> r_seen < r_len)
        else $error("payload count reached declared length inside body");

    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.status == ST_DATA) |-> o_res.payload_index < o_res.payload_length)
        else $error("payload index outside declared length");

    a_err_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (o_res.status == ST_HERR || o_res.status == ST_BERR
                    || o_res.status == ST_OK)) |=> r_phase == PH_HUNT)
        else $error("frame end did not return to hunting");

    a_hdr_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == PH_HCHK && o_res.status == ST_HDR)
        |=> (r_seen == 8'd0 && r_sum == 8'd0))
        else $error("body counters not cleared after good header");

endmodule

// ===== design/gimbal_frame_deframer_top.sv =====
// Byte-serial frame parser: hunts for the start byte '>', checks the command/length header
// against its additive checksum, forwards each payload byte with its index and checks the
// mod-256 body checksum. Every input beat yields exactly one result beat carrying a status
// code. One beat is taken per clock cycle while the output is not stalled; the path has two
// register stages, the input register and the result register: a beat accepted into the
// input register moves into the result register when the output is free, with the whole
// per-byte phase and checksum update done combinationally between them. Output backpressure
// stalls both registers, and input ready follows output ready combinationally.
module gimbal_frame_deframer_top (
    input logic       i_clk,
    input logic       i_rst_n,
    gfd_in_if.sink    i_rx,
    gfd_out_if.source o_res
);
    import gfd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out_data;
    t_result    res;
    logic       out_free;
    logic       step;

    assign out_free   = !r_out_valid || o_res.ready;
    assign step       = r_in_valid && out_free;
    assign i_rx.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    gfd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= res;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out_data;

endmodule

// ===== sim/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gfd_pkg::*;

    localparam int N_DIRECTED      = 24;
    localparam int ITEMS_PER_PHASE = 400;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 4000;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       known;
        t_result    res;
    } t_stim_row;

    typedef struct packed {
        logic    known;
        t_result res;
    } t_fixed_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    gfd_in_if  rx_if ();
    gfd_out_if res_if ();

    gimbal_frame_deframer_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if.sink),
        .o_res   (res_if.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_phase     ph     = PH_HUNT;
    logic [7:0] fr_cmd = 8'h00;
    logic [7:0] fr_len = 8'h00;
    logic [7:0] n_seen = 8'h00;
    logic [7:0] sum    = 8'h00;

    t_result       expected_results [$];
    t_fixed_result fixed_results [$];
    int            mismatches = 0;
    int            sent_items = 0;
    int            idle_cycles = 0;
    int            sender_idle_pct = 0;
    int            receiver_stall_pct = 0;
    bit            hold_off_req = 1'b0;

    int sender_pct_plan [4]   = '{0, 63, 0, 29};
    int receiver_pct_plan [4] = '{0, 0, 63, 29};

    t_stim_row directed_rows [N_DIRECTED] = '{
        {8'h00,      1'b1, ST_DROP, 8'h00, 8'h00, 8'h00, 8'h00},
        {8'hFF,      1'b1, ST_DROP, 8'h00, 8'h00, 8'h00, 8'h00},
        {START_BYTE, 1'b1, ST_HDR,  8'h00, 8'h00, 8'h00, 8'h00},
        {8'hFF,      1'b1, ST_HDR,  8'h00, 8'h00, 8'hFF, 8'h00},
        {8'h02,      1'b1, ST_HDR,  8'h00, 8'h00, 8'hFF, 8'h02},
        {8'h01,      1'b1, ST_HDR,  8'h00, 8'h00, 8'hFF, 8'h02},
        {8'hFF,      1'b1, ST_DATA, 8'hFF, 8'h00, 8'hFF, 8'h02},
        {START_BYTE, 1'b0, ST_DROP, 8'h00, 8'h00, 8'h00, 8'h00},
        {8'h3D,      1'b0, ST_DROP, 8'h00, 8'h00, 8'h00, 8'h00},
        {START_BYTE, 1'b1, ST_HDR,  8'h00, 8'h00, 8'h00, 8'h00},
        {8'h00,      1'b1, ST_HDR,  8'h00, 8'h00, 8'h00, 8'h00},
        {8'h00,      1'b1, ST_HDR,  8'h00, 8'h00, 8'h00, 8'h00},
        {8'h00,      1'b1, ST_HDR,  8'h00, 8'h00, 8'h00, 8'h00},
        {8'h01,      1'b1, ST_BERR, 8'h00, 8'h00, 8'h00, 8'h00},
        {START_BYTE, 1'b1, ST_HDR,  8'h00, 8'h00, 8'h00, 8'h00},
        {8'h12,      1'b1, ST_HDR,  8'h00, 8'h00, 8'h12, 8'h00},
        {8'h34,      1'b1, ST_HDR,  8'h00, 8'h00, 8'h12, 8'h34},
        {8'h00,      1'b1, ST_HERR, 8'h00, 8'h00, 8'h12, 8'h34},
        {START_BYTE, 1'b1, ST_HDR,  8'h00, 8'h00, 8'h00, 8'h00},
        {START_BYTE, 1'b1, ST_HDR,  8'h00, 8'h00, 8'h3E, 8'h00},
        {8'h00,      1'b1, ST_HDR,  8'h00, 8'h00, 8'h3E, 8'h00},
        {START_BYTE, 1'b1, ST_HDR,  8'h00, 8'h00, 8'h3E, 8'h00},
        {8'h00,      1'b1, ST_OK,   8'h00, 8'h00, 8'h3E, 8'h00},
        {8'h3F,      1'b1, ST_DROP, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    function automatic t_result deframe_byte(input logic [7:0] b);
        t_result r;
        r = '0;
        case (ph)
            PH_CMD: begin
                fr_cmd   = b;
                r.status = ST_HDR;
                ph       = PH_LEN;
            end
            PH_LEN: begin
                fr_len   = b;
                r.status = ST_HDR;
                ph       = PH_HCHK;
            end
            PH_HCHK: begin
                if (b == 8'(fr_cmd + fr_len)) begin
                    r.status = ST_HDR;
                    n_seen   = 8'h00;
                    sum      = 8'h00;
                    ph       = (fr_len == 8'h00) ? PH_BCHK : PH_BODY;
                end else begin
                    r.status = ST_HERR;
                    ph       = PH_HUNT;
                end
            end
            PH_BODY: begin
                r.status        = ST_DATA;
                r.payload_byte  = b;
                r.payload_index = n_seen;
                sum             = 8'(sum + b);
                n_seen          = 8'(n_seen + 8'h01);
                if (n_seen == fr_len) ph = PH_BCHK;
            end
            PH_BCHK: begin
                r.status = (b == sum) ? ST_OK : ST_BERR;
                ph       = PH_HUNT;
            end
            default: begin
                if (b == START_BYTE) begin
                    fr_cmd   = 8'h00;
                    fr_len   = 8'h00;
                    n_seen   = 8'h00;
                    sum      = 8'h00;
                    r.status = ST_HDR;
                    ph       = PH_CMD;
                end else begin
                    r.status = ST_DROP;
                    ph       = PH_HUNT;
                end
            end
        endcase
        if (r.status != ST_DROP) begin
            r.command_id     = fr_cmd;
            r.payload_length = fr_len;
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %02h, got %02h", $realtime, field, want, got);
    endtask

    task automatic check_result(input t_result want, input t_result got);
        if (got.status !== want.status)
            flag_mismatch("status", 8'(want.status), 8'(got.status));
        if (got.payload_byte !== want.payload_byte)
            flag_mismatch("payload_byte", want.payload_byte, got.payload_byte);
        if (got.payload_index !== want.payload_index)
            flag_mismatch("payload_index", want.payload_index, got.payload_index);
        if (got.command_id !== want.command_id)
            flag_mismatch("command_id", want.command_id, got.command_id);
        if (got.payload_length !== want.payload_length)
            flag_mismatch("payload_length", want.payload_length, got.payload_length);
    endtask

    always @(posedge i_clk) begin
        t_fixed_result fx;
        t_result       predicted;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected result beat, status %0d", $realtime,
                                 res_if.data.status);
                end else begin
                    check_result(expected_results.pop_front(), res_if.data);
                end
            end
            if (rx_if.valid && rx_if.ready) begin
                fx        = fixed_results.pop_front();
                predicted = deframe_byte(rx_if.rx_byte);
                expected_results.push_back(fx.known ? fx.res : predicted);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("gimbal_frame_deframer_top regression: fail");
            $finish;
        end
    end

    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end
            res_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic known, input t_result res);
        t_fixed_result fx;
        fx = {known, res};
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            rx_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        fixed_results.push_back(fx);
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        sent_items++;
    endtask

    task automatic send_frame();
        logic [7:0] cmd;
        logic [7:0] len;
        logic [7:0] hchk;
        logic [7:0] bsum;
        logic [7:0] b;
        int         kind;
        int         pick;
        int         cut;
        kind = $urandom_range(99);
        pick = $urandom_range(99);
        cmd  = 8'($urandom);
        if (pick < 10)
            len = 8'h00;
        else if (pick < 11)
            len = 8'hFF;
        else if (pick < 14)
            len = 8'($urandom_range(13, 254));
        else
            len = 8'($urandom_range(1, 12));
        hchk = 8'(cmd + len);
        if (kind < 10) hchk = hchk ^ 8'($urandom_range(1, 255));
        send_byte(START_BYTE, 1'b0, '0);
        send_byte(cmd, 1'b0, '0);
        send_byte(len, 1'b0, '0);
        send_byte(hchk, 1'b0, '0);
        if (kind < 10) return;
        // for some frames, truncate the body so the next frame lands mid-payload
        cut  = (kind < 16) ? $urandom_range(0, len) : len;
        bsum = 8'h00;
        for (int i = 0; i < cut; i++) begin
            b    = 8'($urandom);
            bsum = 8'(bsum + b);
            send_byte(b, 1'b0, '0);
        end
        if (kind < 16) return;
        if (kind < 28) bsum = bsum ^ 8'($urandom_range(1, 255));
        send_byte(bsum, 1'b0, '0);
    endtask

    initial begin
        int target;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'h00;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_byte(directed_rows[i].rx_byte, directed_rows[i].known, directed_rows[i].res);

        for (int p = 0; p < 4; p++) begin
            sender_idle_pct    = sender_pct_plan[p];
            receiver_stall_pct = receiver_pct_plan[p];
            if (p == 0) hold_off_req = 1'b1;
            target = sent_items + ITEMS_PER_PHASE;
            while (sent_items < target) begin
                if ($urandom_range(99) < 20) begin
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0, '0);
                end else begin
                    send_frame();
                end
            end
        end

        @(negedge i_clk);
        rx_if.valid <= 1'b0;
        receiver_stall_pct = 0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("gimbal_frame_deframer_top regression: pass");
        end else begin
            $display("gimbal_frame_deframer_top regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/gfd_pkg.sv
design/gfd_if.sv
design/gfd_parser.sv
design/gimbal_frame_deframer_top.sv
sim/tb.sv
